// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl files
// each macro expands to one labeled concurrent assertion clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ddo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 30;

  localparam int CIRC_W   = 20;
  localparam int INV_AX_W = 24;
  localparam int SPEED_W  = 24;
  localparam int TIME_W   = 32;
  localparam int OUT_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int CV_W     = 34;   // cordic vector and angle width

  localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AXLE = 1'd1;

  localparam logic [CIRC_W-1:0]   CIRC_RESET   = 20'd32768;
  localparam logic [INV_AX_W-1:0] INV_AX_RESET = 24'd65536;

  // 2^32 / (2*pi), rounded
  localparam logic [29:0] INV_TWO_PI_BAM = 30'd683565276;
  // cordic gain compensation in q4.30
  localparam logic signed [CV_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [CV_W-1:0] cs;
    logic signed [CV_W-1:0] sn;
  } cordic_out_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [31:0] atan_bam(logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/diff_drive_odometry_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Differential-drive odometry with midpoint-heading pose integration.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one wheel sample per transfer (left and right speed,
//   timestamp); m_axis returns one pose and speed record per sample.
//   cfg_we/cfg_index/cfg_data write the circumference and inverse axle
//   length; the user must write them only while no sample is in flight,
//   as the block itself does not enforce it. Each sample passes through
//   nine 34x34 multiplier steps, the cordic wait, six multiplier steps for
//   the increments, the output step and idle.
//   s_axis_tready is high only while the sequencer is idle, so a new sample
//   is taken once the previous record sits in the output register; if the
//   receiver stalls, the next record waits in the last step until the
//   output register frees.
//   Reset clears pose, heading and time, restores the register defaults
//   and drops m_axis_tvalid. The first sample after reset records
//   its timestamp and leaves the pose unchanged.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // left_speed[23:0], right_speed[47:24], sample_time[79:48]
  input  logic [79:0]                      s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[95:64], linear_speed[127:96],
  // angular_speed[159:128]
  output logic [159:0]                     m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ddo_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_M5   = 5'd5;
  localparam logic [4:0] S_M6   = 5'd6;
  localparam logic [4:0] S_M7   = 5'd7;
  localparam logic [4:0] S_M8   = 5'd8;
  localparam logic [4:0] S_M9   = 5'd9;
  localparam logic [4:0] S_CW   = 5'd10;
  localparam logic [4:0] S_X1   = 5'd11;
  localparam logic [4:0] S_X2   = 5'd12;
  localparam logic [4:0] S_X3   = 5'd13;
  localparam logic [4:0] S_X4   = 5'd14;
  localparam logic [4:0] S_X5   = 5'd15;
  localparam logic [4:0] S_X6   = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  localparam logic signed [50:0] MAX51 = 51'sd2147483647;
  localparam logic signed [50:0] MIN51 = -51'sd2147483648;

  function automatic logic signed [31:0] sat32(logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > MAX51)
      r = 32'sh7FFFFFFF;
    else if (v < MIN51)
      r = 32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

  logic [4:0] state;

  // configuration
  logic [CIRC_W-1:0]   circ;
  logic [INV_AX_W-1:0] inv_ax;

  // pose state
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic [31:0]        heading;
  logic [TIME_W-1:0]  last_time;
  logic               time_seen;

  // per-sample working registers
  logic signed [SPEED_W-1:0] left;
  logic signed [SPEED_W-1:0] right;
  logic [TIME_W-1:0]         dt;
  logic signed [27:0]        v;
  logic signed [31:0]        w;
  logic [31:0]               turn_lo;
  logic [32:0]               fa;
  logic [32:0]               full;
  logic signed [44:0]        travel;
  logic signed [CV_W-1:0]    cs;
  logic signed [CV_W-1:0]    sn;
  logic signed [34:0]        part;
  logic signed [63:0]        acc;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  logic signed [24:0] sum_lr;
  logic signed [24:0] dif_lr;
  logic signed [36:0] w_wide;
  logic signed [50:0] x_sum;
  logic signed [50:0] y_sum;
  logic [TIME_W-1:0]  t_in;
  logic               out_load;

  cordic_req_t creq;
  cordic_out_t cres;

  assign s_axis_tready = (state == S_IDLE);
  assign t_in   = s_axis_tdata[79:48];
  assign sum_lr = {left[SPEED_W-1], left} + {right[SPEED_W-1], right};
  assign dif_lr = {right[SPEED_W-1], right} - {left[SPEED_W-1], left};
  assign w_wide = prod[52:16];
  assign x_sum  = {{19{x_pos[31]}}, x_pos} + {acc[63], acc[63:14]};
  assign y_sum  = {{19{y_pos[31]}}, y_pos} + {acc[63], acc[63:14]};
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  assign creq.start = (state == S_M9);
  assign creq.angle = heading + full[32:1];

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .res (cres)
  );

  // operand selection for the multiplier step of each state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = {{9{sum_lr[24]}}, sum_lr};
        mul_b = {14'd0, circ};
      end
      S_M2: begin
        mul_a = {{9{dif_lr[24]}}, dif_lr};
        mul_b = {14'd0, circ};
      end
      S_M3: begin
        mul_a = {{5{prod[44]}}, prod[44:16]};
        mul_b = {10'd0, inv_ax};
      end
      S_M5: begin
        mul_a = {{2{w[31]}}, w};
        mul_b = {2'd0, dt};
      end
      S_M6: begin
        mul_a = {{2{prod[63]}}, prod[63:32]};
        mul_b = {4'd0, INV_TWO_PI_BAM};
      end
      S_M7: begin
        mul_a = {2'd0, turn_lo};
        mul_b = {4'd0, INV_TWO_PI_BAM};
      end
      S_M8: begin
        mul_a = {{6{v[27]}}, v};
        mul_b = {2'd0, dt};
      end
      S_X1: begin
        mul_a = {18'd0, travel[15:0]};
        mul_b = cs;
      end
      S_X2: begin
        mul_a = {{5{travel[44]}}, travel[44:16]};
        mul_b = cs;
      end
      S_X3: begin
        mul_a = {18'd0, travel[15:0]};
        mul_b = sn;
      end
      S_X4: begin
        mul_a = {{5{travel[44]}}, travel[44:16]};
        mul_b = sn;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      circ   <= CIRC_RESET;
      inv_ax <= INV_AX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CIRC:     circ   <= cfg_data[CIRC_W-1:0];
        REG_INV_AXLE: inv_ax <= cfg_data[INV_AX_W-1:0];
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // sequencer and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      x_pos         <= '0;
      y_pos         <= '0;
      heading       <= '0;
      last_time     <= '0;
      time_seen     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last_time <= t_in;
            time_seen <= 1'b1;
            state     <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_M5;
        S_M5: state <= S_M6;
        S_M6: state <= S_M7;
        S_M7: state <= S_M8;
        S_M8: state <= S_M9;
        S_M9: state <= S_CW;
        S_CW: begin
          if (cres.done)
            state <= S_X1;
        end
        S_X1: state <= S_X2;
        S_X2: state <= S_X3;
        S_X3: state <= S_X4;
        S_X4: begin
          x_pos <= sat32(x_sum);
          state <= S_X5;
        end
        S_X5: state <= S_X6;
        S_X6: begin
          y_pos   <= sat32(y_sum);
          heading <= heading + full[31:0];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_load)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        left  <= s_axis_tdata[23:0];
        right <= s_axis_tdata[47:24];
        dt    <= time_seen ? (t_in - last_time) : '0;
      end
      S_M2: v <= prod[44:17];
      S_M4: begin
        if (w_wide > 37'sh007FFFFFFF)
          w <= 32'sh7FFFFFFF;
        else if (w_wide < -37'sh0080000000)
          w <= 32'sh80000000;
        else
          w <= w_wide[31:0];
      end
      S_M6: turn_lo <= prod[31:0];
      S_M7: fa <= prod[32:0];
      S_M8: full <= fa + prod[64:32];
      S_M9: travel <= prod[60:16];
      S_CW: begin
        cs <= cres.cs;
        sn <= cres.sn;
      end
      S_X2: part <= prod[50:16];
      S_X3: acc <= prod[63:0] + {{29{part[34]}}, part};
      S_X4: part <= prod[50:16];
      S_X5: acc <= prod[63:0] + {{29{part[34]}}, part};
      S_OUT: begin
        if (out_load) begin
          m_axis_tdata[31:0]    <= x_pos;
          m_axis_tdata[63:32]   <= y_pos;
          m_axis_tdata[95:64]   <= heading;
          m_axis_tdata[127:96]  <= {{4{v[27]}}, v};
          m_axis_tdata[159:128] <= w;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input accepted again while busy")
  `ASSERT_CLK(a_cordic_done_in_wait, cres.done |-> (state == S_CW), "cordic result outside the wait step")
  `ASSERT_CLK(a_out_from_last_step, $rose(m_axis_tvalid) |-> ($past(state) == S_OUT), "result raised outside the output step")
  `ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

// ----- src/ddo_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, giving
// cosine and sine in q4.30 of a binary angle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ddo_pkg::cordic_req_t req,
  output ddo_pkg::cordic_out_t res
);
  import ddo_pkg::*;

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                   busy;
  logic                   done;
  logic [IW-1:0]          iter;
  logic [1:0]             quad;
  logic signed [CV_W-1:0] x;
  logic signed [CV_W-1:0] y;
  logic signed [CV_W-1:0] z;

  logic [1:0]             quad_in;
  logic [31:0]            rem;
  logic signed [CV_W-1:0] xs;
  logic signed [CV_W-1:0] ys;
  logic signed [CV_W-1:0] at;

  // fold to the nearest quarter turn, residual in [-2^29, 2^29)
  assign quad_in = 2'((req.angle + 32'h20000000) >> 30);
  assign rem     = req.angle - {quad_in, 30'd0};

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = {2'd0, atan_bam(5'(iter))};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= CORDIC_GAIN_Q30;
      y    <= '0;
      z    <= {{2{rem[31]}}, rem};
      quad <= quad_in;
    end else if (busy) begin
      if (!z[CV_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  // exact quarter-turn rotation of the result
  always_comb begin
    res.done = done;
    case (quad)
      2'd0: begin
        res.cs = x;
        res.sn = y;
      end
      2'd1: begin
        res.cs = -y;
        res.sn = x;
      end
      2'd2: begin
        res.cs = -x;
        res.sn = -y;
      end
      default: begin
        res.cs = y;
        res.sn = -x;
      end
    endcase
  end

endmodule
